### rtl/ttpq_pkg.sv
package ttpq_pkg;

    // command codes carried in the request tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result status codes carried in the result tuser
    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DISPATCH = 2'd2;
    localparam logic [1:0] ST_NONE_DUE = 2'd3;

    localparam logic [2:0] KIND_SET_FREE = 3'd4;

    // most tasks one tick may dispatch
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 112;

    typedef struct packed {
        logic [31:0] due_time;
        logic [15:0] urgency;
        logic [2:0]  kind;
        logic [7:0]  body_id;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } t_entry;

    // true when task a sorts strictly ahead of stored task b
    function automatic logic goes_before(input t_entry a, input t_entry b);
        logic r;
        if (a.due_time != b.due_time) begin
            r = a.due_time < b.due_time;
        end else if (a.urgency != b.urgency) begin
            r = a.urgency > b.urgency;
        end else begin
            r = (a.kind != KIND_SET_FREE) && (b.kind == KIND_SET_FREE);
        end
        return r;
    endfunction

endpackage

### rtl/timed_task_priority_queue.sv
// channel   dir  signals                       contents
// request   in   i_s_axis_tvalid/o_s_axis_tready
//                i_s_axis_tdata [175:0]        due_time, kind, body_id, value_x/y/z,
//                                              urgency, step_len
//                i_s_axis_tuser [0]            cmd (0 add, 1 tick)
// result    out  o_m_axis_tvalid/i_m_axis_tready
//                o_m_axis_tdata [111:0]        out_kind, out_body, out_x/y/z
//                o_m_axis_tuser [1:0]          status
//                o_m_axis_tlast                last result of the request
//
// an add walks the store from the tail down, one stored task per cycle through the
// single compare unit and memory port
// a tick checks one task per cycle from the head unless the result register is full
// one request at a time; a full result register holds a tick or a final result in place
// synchronous active-low reset clears the count, head, time and control; the
// task memory itself is not cleared
module timed_task_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // due_time[31:0], kind[34:32], body_id[42:35], value_x[74:43], value_y[106:75],
    // value_z[138:107], urgency[154:139], step_len[170:155], zero pad
    input  logic [ttpq_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // cmd[0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // out_kind[2:0], out_body[10:3], out_x[42:11], out_y[74:43], out_z[106:75], zero pad
    output logic [ttpq_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import ttpq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = IW + 1;     // fill count, also holds head + fill
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_I  = IW'(QUEUE_DEPTH - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] x);
        return (x == '0) ? LAST_I : x - IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] x);
        return (x == LAST_I) ? '0 : x + IW'(1);
    endfunction

    // task store, circular with the earliest task at the head
    t_entry          mem [QUEUE_DEPTH];
    t_entry          r_rd;
    logic            mem_we;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;
    logic [IW-1:0]   rd_addr;

    logic [1:0]       r_state, n_state;
    logic [FW-1:0]    r_fill,  n_fill;
    logic [IW-1:0]    r_head,  n_head;
    logic [IW-1:0]    r_cur,   n_cur;     // insert slot being filled
    logic [FW-1:0]    r_left,  n_left;    // stored tasks still below the insert slot
    logic [31:0]      r_now,   n_now;
    logic [15:0]      r_step,  n_step;
    logic [CNT_W-1:0] r_cnt,   n_cnt;     // tasks dispatched by this tick
    logic             r_have,  n_have;    // a dispatched task waits for its last flag
    t_entry           r_pend,  n_pend;
    t_entry           r_new,   n_new;
    logic [1:0]       r_status, n_status;

    logic             r_ovalid, n_ovalid;
    logic [1:0]       r_ouser,  n_ouser;
    logic             r_olast,  n_olast;
    t_entry           r_odata,  n_odata;

    logic             s_acc;
    logic             out_free;
    logic             due;
    logic [FW-1:0]    tail_sum;
    logic [IW-1:0]    tail;
    logic [32:0]      now_sum;
    t_entry           in_entry;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = i_s_axis_tvalid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || i_m_axis_tready;

    assign in_entry.due_time = i_s_axis_tdata[31:0];
    assign in_entry.kind     = i_s_axis_tdata[34:32];
    assign in_entry.body_id  = i_s_axis_tdata[42:35];
    assign in_entry.vx       = i_s_axis_tdata[74:43];
    assign in_entry.vy       = i_s_axis_tdata[106:75];
    assign in_entry.vz       = i_s_axis_tdata[138:107];
    assign in_entry.urgency  = i_s_axis_tdata[154:139];

    // slot one past the last task in order; fill stays below the depth on an insert
    assign tail_sum = FW'(r_head) + r_fill;
    assign tail     = (tail_sum >= DEPTH_F) ? IW'(tail_sum - DEPTH_F) : IW'(tail_sum);

    // saturating time advance
    assign now_sum = {1'b0, r_now} + {17'd0, r_step};

    // a tick stops at the first task not yet due, an empty store or the result cap
    assign due = (r_fill != '0) && (r_cnt != CNT_W'(MAX_RESULTS)) && (r_rd.due_time <= r_now);

    // the tick walks from the head, the insert reads the task below its slot
    assign rd_addr = (n_state == S_TICK) ? n_head : idx_prev(n_cur);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_head   = r_head;
        n_cur    = r_cur;
        n_left   = r_left;
        n_now    = r_now;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_have   = r_have;
        n_pend   = r_pend;
        n_new    = r_new;
        n_status = r_status;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ouser  = r_ouser;
        n_olast  = r_olast;
        n_odata  = r_odata;
        mem_we   = 1'b0;
        wr_addr  = r_cur;
        wr_data  = r_new;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    if (i_s_axis_tuser == CMD_ADD) begin
                        n_new = in_entry;
                        if (r_fill == DEPTH_F) begin
                            n_status = ST_DROPPED;
                            n_state  = S_EMIT;
                        end else begin
                            n_cur   = tail;
                            n_left  = r_fill;
                            n_state = S_INS;
                        end
                    end else begin
                        n_step  = i_s_axis_tdata[170:155];
                        n_cnt   = '0;
                        n_have  = 1'b0;
                        n_state = S_TICK;
                    end
                end
            end
            S_INS: begin
                mem_we = 1'b1;
                if ((r_left != '0) && goes_before(r_new, r_rd)) begin
                    // later task moves up one slot
                    wr_data = r_rd;
                    n_cur   = idx_prev(r_cur);
                    n_left  = r_left - FW'(1);
                end else begin
                    wr_data  = r_new;
                    n_fill   = r_fill + FW'(1);
                    n_status = ST_ADDED;
                    n_state  = S_EMIT;
                end
            end
            S_TICK: begin
                if (due) begin
                    if (!r_have || out_free) begin
                        if (r_have) begin
                            n_ovalid = 1'b1;
                            n_ouser  = ST_DISPATCH;
                            n_odata  = r_pend;
                            n_olast  = 1'b0;
                        end
                        n_pend = r_rd;
                        n_have = 1'b1;
                        n_head = idx_next(r_head);
                        n_fill = r_fill - FW'(1);
                        n_cnt  = r_cnt + CNT_W'(1);
                    end
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_olast  = 1'b1;
                    if (r_have) begin
                        n_ouser = ST_DISPATCH;
                        n_odata = r_pend;
                    end else begin
                        n_ouser = ST_NONE_DUE;
                        n_odata = '0;
                    end
                    n_now   = now_sum[32] ? 32'hFFFF_FFFF : now_sum[31:0];
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ouser  = r_status;
                    n_odata  = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_head   <= '0;
            r_cur    <= '0;
            r_left   <= '0;
            r_now    <= '0;
            r_cnt    <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_head   <= n_head;
            r_cur    <= n_cur;
            r_left   <= n_left;
            r_now    <= n_now;
            r_cnt    <= n_cnt;
            r_have   <= n_have;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_step   <= n_step;
        r_pend   <= n_pend;
        r_new    <= n_new;
        r_status <= n_status;
        r_ouser  <= n_ouser;
        r_olast  <= n_olast;
        r_odata  <= n_odata;
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tdata  = {5'd0, r_odata.vz, r_odata.vy, r_odata.vx,
                              r_odata.body_id, r_odata.kind};

endmodule

### dv/tb_timed_task_priority_queue.sv
`timescale 1ns / 1ps

module tb_timed_task_priority_queue;
    import ttpq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int MAX_GAP       = 20;

    typedef struct packed {
        logic        cmd;
        logic [31:0] due_time;
        logic [2:0]  kind;
        logic [7:0]  body_id;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [15:0] urgency;
        logic [15:0] step_len;
    } task_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  kind;
        logic [7:0]  body;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } reply_t;

    logic                  clk;
    logic                  rst_n   = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data  = '0;
    logic                  s_user  = CMD_ADD;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;
    logic [1:0]            m_user;
    logic                  m_last;

    wire req_fire = s_valid && s_ready;
    wire res_fire = m_valid && m_ready;

    timed_task_priority_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // schedule mirror: stored tasks in dispatch order and the current time
    t_entry      task_store[$];
    logic [31:0] sched_now = '0;
    reply_t      queue_replies[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int n_errors     = 0;
    int n_requests   = 0;
    int n_adds       = 0;
    int n_ticks      = 0;
    int n_dropped    = 0;
    int n_dispatched = 0;
    int n_idle_ticks = 0;
    int n_checked    = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // true when task a is dispatched strictly before stored task b
    function automatic logic ahead_of(input t_entry a, input t_entry b);
        if (a.due_time != b.due_time) begin
            return a.due_time < b.due_time;
        end
        if (a.urgency != b.urgency) begin
            return a.urgency > b.urgency;
        end
        return (a.kind != KIND_SET_FREE) && (b.kind == KIND_SET_FREE);
    endfunction

    function automatic void apply_to_schedule(input task_req_t r);
        t_entry ne;
        reply_t rep;
        int     pos;
        int     n_due;
        rep = '0;
        if (r.cmd == CMD_ADD) begin
            n_adds++;
            if (task_store.size() >= DEPTH) begin
                rep.status = ST_DROPPED;
                n_dropped++;
            end else begin
                ne.due_time = r.due_time;
                ne.urgency  = r.urgency;
                ne.kind     = r.kind;
                ne.body_id  = r.body_id;
                ne.vx       = r.vx;
                ne.vy       = r.vy;
                ne.vz       = r.vz;
                pos = 0;
                while (pos < task_store.size() && !ahead_of(ne, task_store[pos])) begin
                    pos++;
                end
                task_store.insert(pos, ne);
                rep.status = ST_ADDED;
            end
            rep.last = 1'b1;
            queue_replies.push_back(rep);
        end else begin
            n_ticks++;
            n_due = 0;
            while (n_due < task_store.size() && n_due < MAX_RESULTS &&
                   task_store[n_due].due_time <= sched_now) begin
                n_due++;
            end
            if (n_due == 0) begin
                rep.status = ST_NONE_DUE;
                rep.last   = 1'b1;
                queue_replies.push_back(rep);
                n_idle_ticks++;
            end
            for (int i = 0; i < n_due; i++) begin
                ne = task_store.pop_front();
                rep.status = ST_DISPATCH;
                rep.kind   = ne.kind;
                rep.body   = ne.body_id;
                rep.x      = ne.vx;
                rep.y      = ne.vy;
                rep.z      = ne.vz;
                rep.last   = (i == n_due - 1);
                queue_replies.push_back(rep);
                n_dispatched++;
            end
            // time saturates instead of wrapping
            if (sched_now > 32'hFFFF_FFFF - {16'd0, r.step_len}) begin
                sched_now = 32'hFFFF_FFFF;
            end else begin
                sched_now = sched_now + {16'd0, r.step_len};
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("mismatch at %0t:%s", $realtime, msg);
        end
    endtask

    // fields that the command does not use are random
    function automatic task_req_t random_request(input logic cmd);
        task_req_t r;
        r.cmd      = cmd;
        r.due_time = $urandom;
        r.kind     = 3'($urandom_range(7));
        r.body_id  = 8'($urandom_range(255));
        r.vx       = $urandom;
        r.vy       = $urandom;
        r.vz       = $urandom;
        r.urgency  = 16'($urandom_range(16'hFFFF));
        r.step_len = 16'($urandom_range(16'hFFFF));
        return r;
    endfunction

    task automatic send_request(input task_req_t r);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= r.cmd;
        s_data  <= {5'd0, r.step_len, r.urgency, r.vz, r.vy, r.vx, r.body_id, r.kind,
                    r.due_time};
        do @(posedge clk); while (!s_ready);
        apply_to_schedule(r);
        n_requests++;
    endtask

    task automatic send_add(input logic [31:0] due, input logic [15:0] urg,
                            input logic [2:0] kind, input logic [7:0] body,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        task_req_t r;
        r = random_request(CMD_ADD);
        r.due_time = due;
        r.urgency  = urg;
        r.kind     = kind;
        r.body_id  = body;
        r.vx       = x;
        r.vy       = y;
        r.vz       = z;
        send_request(r);
    endtask

    task automatic send_tick(input logic [15:0] step);
        task_req_t r;
        r = random_request(CMD_TICK);
        r.step_len = step;
        send_request(r);
    endtask

    // sender holds off until every reply is in
    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge clk); while (queue_replies.size() != 0);
    endtask

    task automatic test_ordering();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick(16'd0);
        send_add(32'd0, 16'd0, 3'd0, 8'h00, 32'h0, 32'h0, 32'h0);
        send_add(32'd0, 16'hFFFF, KIND_SET_FREE, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF);
        // same time and urgency: ordinary kind goes ahead of set free
        send_add(32'd0, 16'hFFFF, 3'd0, 8'h01, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1);
        send_add(32'd0, 16'hFFFF, 3'd7, 8'h02, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
        send_add(32'd0, 16'hFFFF, KIND_SET_FREE, 8'h03, 32'h1, 32'h2, 32'h3);
        send_add(32'd1, 16'd8, 3'd1, 8'h10, 32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
        send_add(32'hFFFF_FFFF, 16'd0, 3'd2, 8'h20, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0);
        send_add(32'hFFFF_FFFF, 16'hFFFF, 3'd3, 8'h30, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h1234_5678);
        send_add(32'd2, 16'd0, 3'd5, 8'h40, 32'h0, 32'h0, 32'h8000_0000);
        send_add(32'd2, 16'd0, 3'd6, 8'h50, 32'h8000_0000, 32'h0, 32'h0);
        send_add(32'd1, 16'd9, KIND_SET_FREE, 8'h60, 32'h1, 32'h1, 32'h1);
        send_tick(16'd0);
        send_tick(16'hFFFF);
        send_tick(16'd1);
        send_tick(16'd0);
        drain_replies();
    endtask

    task automatic test_random_traffic();
        int send_mix[4] = '{0, 53, 0, 6};
        int recv_mix[4] = '{0, 0, 53, 6};
        logic [31:0] due;
        logic [15:0] urg;
        logic [2:0]  kind;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(99) < 55) begin
                    // mostly near the current time so that ticks find work
                    case ($urandom_range(9))
                        0:       due = sched_now + 32'($urandom_range(200000));
                        1:       due = sched_now;
                        default: due = sched_now + 32'($urandom_range(48));
                    endcase
                    urg  = ($urandom_range(3) == 0) ? 16'($urandom_range(16'hFFFF))
                                                    : 16'($urandom_range(3));
                    kind = ($urandom_range(9) < 3) ? KIND_SET_FREE
                                                   : 3'($urandom_range(7));
                    send_add(due, urg, kind, 8'($urandom_range(255)), $urandom, $urandom,
                             $urandom);
                end else begin
                    send_tick(($urandom_range(4) == 0) ? 16'($urandom_range(16'hFFFF))
                                                       : 16'($urandom_range(24)));
                end
            end
            drain_replies();
        end
    endtask

    task automatic test_store_full();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        // late tasks fill every slot, then adds bounce off
        while (task_store.size() < DEPTH) begin
            send_add(sched_now + 32'd100000 + 32'($urandom_range(255)),
                     16'($urandom_range(3)), 3'($urandom_range(7)),
                     8'($urandom_range(255)), $urandom, $urandom, $urandom);
        end
        send_add(32'd0, 16'hFFFF, 3'd0, 8'hAA, 32'h1, 32'h2, 32'h3);
        send_add(32'hFFFF_FFFF, 16'd0, KIND_SET_FREE, 8'h55, 32'h0, 32'h0, 32'h0);
        send_tick(16'd0);
        send_add(32'd7, 16'd7, 3'd1, 8'h77, $urandom, $urandom, $urandom);
        drain_replies();
    endtask

    task automatic test_full_dispatch();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // large steps until every stored task has gone out
        while (task_store.size() != 0) begin
            send_tick(16'hFFFF);
        end
        // a full store of tasks already due leaves in a single tick
        for (int i = 0; i < DEPTH; i++) begin
            send_add(sched_now, 16'($urandom_range(3)), 3'($urandom_range(7)), 8'(i),
                     $urandom, $urandom, $urandom);
        end
        send_tick(16'hFFFF);
        send_tick(16'd0);
        send_add(32'hFFFF_FFFF, 16'd1, 3'd2, 8'h11, $urandom, $urandom, $urandom);
        send_tick(16'hFFFF);
        drain_replies();
    endtask

    initial begin : reply_checker
        reply_t want;
        reply_t got;
        string  diff;
        forever begin
            @(posedge clk);
            if (rst_n && res_fire) begin
                got.status = m_user;
                got.kind   = m_data[2:0];
                got.body   = m_data[10:3];
                got.x      = m_data[42:11];
                got.y      = m_data[74:43];
                got.z      = m_data[106:75];
                got.last   = m_last;
                n_checked++;
                if (queue_replies.size() == 0) begin
                    report_mismatch($sformatf(" reply with none pending, status %0d",
                                              got.status));
                end else begin
                    want = queue_replies.pop_front();
                    diff = "";
                    if (got.status !== want.status)
                        diff = {diff, $sformatf(" status exp %0d got %0d", want.status,
                                                got.status)};
                    if (got.kind !== want.kind)
                        diff = {diff, $sformatf(" kind exp %0d got %0d", want.kind, got.kind)};
                    if (got.body !== want.body)
                        diff = {diff, $sformatf(" body exp %h got %h", want.body, got.body)};
                    if (got.x !== want.x)
                        diff = {diff, $sformatf(" x exp %h got %h", want.x, got.x)};
                    if (got.y !== want.y)
                        diff = {diff, $sformatf(" y exp %h got %h", want.y, got.y)};
                    if (got.z !== want.z)
                        diff = {diff, $sformatf(" z exp %h got %h", want.z, got.z)};
                    if (got.last !== want.last)
                        diff = {diff, $sformatf(" last exp %b got %b", want.last, got.last)};
                    if (diff != "") begin
                        report_mismatch(diff);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || req_fire || res_fire) begin
                stuck = 0;
            end else begin
                stuck++;
            end
            if (stuck >= WATCHDOG_MAX) begin
                $display("no transfer for %0d cycles, %0d replies pending", stuck,
                         queue_replies.size());
                $display("[timed_task_priority_queue] ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ordering();
        test_random_traffic();
        test_store_full();
        test_full_dispatch();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("ran %0d requests (%0d adds, %0d ticks), %0d replies checked", n_requests,
                 n_adds, n_ticks, n_checked);
        $display("%0d tasks dispatched, %0d adds dropped on a full store,", n_dispatched,
                 n_dropped);
        $display("%0d ticks found nothing due", n_idle_ticks);
        if (n_errors == 0) begin
            $display("[timed_task_priority_queue] OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[timed_task_priority_queue] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/ttpq_pkg.sv
rtl/timed_task_priority_queue.sv
dv/tb_timed_task_priority_queue.sv
